// ----- src/i2cbs_pkg.sv -----
// Shared types, codes and step-table functions for the I2C bit sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2cbs_pkg;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_SEND  = 3'd2,
    OP_RECV  = 3'd3,
    OP_SACK  = 3'd4,
    OP_RACK  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ACT_SDA0 = 3'd0,
    ACT_SDA1 = 3'd1,
    ACT_SCL0 = 3'd2,
    ACT_SCL1 = 3'd3,
    ACT_READ = 3'd4
  } act_t;

  localparam logic [15:0] TPS_RESET = 16'd720;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;

  // One tick's result as seen on the output channel
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       rx_ack;
  } result_t;

  function automatic logic [4:0] step_total(input op_t cmd);
    logic [4:0] n;
    unique case (cmd)
      OP_START: n = 5'd4;
      OP_STOP:  n = 5'd3;
      OP_SEND:  n = 5'd24;
      OP_RECV:  n = 5'd25;
      OP_SACK:  n = 5'd3;
      default:  n = 5'd4;
    endcase
    return n;
  endfunction

  // ph/grp are the position within a three-step bit slot and the bit slot;
  // for receive byte they count from the step after the SDA release.
  function automatic act_t step_action(input op_t cmd, input logic [4:0] idx,
                                       input logic [1:0] ph, input logic [2:0] grp,
                                       input logic [7:0] shift, input logic ack);
    act_t a;
    unique case (cmd)
      OP_START: begin
        unique case (idx[1:0])
          2'd0:    a = ACT_SDA1;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_SDA0;
          default: a = ACT_SCL0;
        endcase
      end
      OP_STOP: begin
        if (idx == 5'd0)      a = ACT_SDA0;
        else if (idx == 5'd1) a = ACT_SCL1;
        else                  a = ACT_SDA1;
      end
      OP_SEND: begin
        if (ph == 2'd0)      a = shift[~grp] ? ACT_SDA1 : ACT_SDA0;
        else if (ph == 2'd1) a = ACT_SCL1;
        else                 a = ACT_SCL0;
      end
      OP_RECV: begin
        if (idx == 5'd0)     a = ACT_SDA1;
        else if (ph == 2'd0) a = ACT_SCL1;
        else if (ph == 2'd1) a = ACT_READ;
        else                 a = ACT_SCL0;
      end
      OP_SACK: begin
        if (idx == 5'd0)      a = ack ? ACT_SDA1 : ACT_SDA0;
        else if (idx == 5'd1) a = ACT_SCL1;
        else                  a = ACT_SCL0;
      end
      default: begin
        unique case (idx[1:0])
          2'd0:    a = ACT_SDA1;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_READ;
          default: a = ACT_SCL0;
        endcase
      end
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- src/i2cbs_core.sv -----
// Sequencer state and per-tick next-state logic for the I2C bit sequencer.
`timescale 1ns / 1ps
`default_nettype none
module i2cbs_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data,
  input  wire logic             tick,
  input  wire logic             cmd_valid,
  input  wire logic [2:0]       opcode,
  input  wire logic [7:0]       tx_byte,
  input  wire logic             ack_to_send,
  input  wire logic             sda_in,
  output i2cbs_pkg::result_t    res
);
  import i2cbs_pkg::*;

  logic [15:0] tps_r;
  op_t         cmd_r,   cmd_nxt;
  logic [4:0]  idx_r,   idx_nxt;
  logic [1:0]  ph_r,    ph_nxt;
  logic [2:0]  grp_r,   grp_nxt;
  logic        run_r,   run_nxt;
  logic [15:0] tc_r,    tc_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r,   scl_nxt;
  logic        sda_r,   sda_nxt;
  logic [7:0]  rxb_r,   rxb_nxt;
  logic        rxa_r,   rxa_nxt;
  logic        ackl_r,  ackl_nxt;
  logic        done;

  function automatic void apply(input act_t a, inout logic scl, inout logic sda);
    unique case (a)
      ACT_SDA0: sda = 1'b0;
      ACT_SDA1: sda = 1'b1;
      ACT_SCL0: scl = 1'b0;
      ACT_SCL1: scl = 1'b1;
      default:  ;
    endcase
  endfunction

  always_comb begin
    act_t a;
    a         = ACT_SDA0;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    ph_nxt    = ph_r;
    grp_nxt   = grp_r;
    run_nxt   = run_r;
    tc_nxt    = tc_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rxb_nxt   = rxb_r;
    rxa_nxt   = rxa_r;
    ackl_nxt  = ackl_r;
    done      = 1'b0;

    if (!run_nxt && cmd_valid && (opcode <= OP_RACK)) begin
      cmd_nxt = op_t'(opcode);
      idx_nxt = 5'd0;
      ph_nxt  = 2'd0;
      grp_nxt = 3'd0;
      tc_nxt  = 16'd0;
      run_nxt = 1'b1;
      if (cmd_nxt == OP_SEND)      shift_nxt = tx_byte;
      else if (cmd_nxt == OP_RECV) shift_nxt = 8'd0;
      if (cmd_nxt == OP_SACK) ackl_nxt = ack_to_send;
      a = step_action(cmd_nxt, 5'd0, 2'd0, 3'd0, shift_nxt, ackl_nxt);
      apply(a, scl_nxt, sda_nxt);
    end

    if (run_nxt) begin
      if (tc_nxt < TICK_MAX) tc_nxt = tc_nxt + 16'd1;
      // a zero setting behaves as one since the count is already at least one
      if (tc_nxt >= tps_r) begin
        a = step_action(cmd_nxt, idx_nxt, ph_nxt, grp_nxt, shift_nxt, ackl_nxt);
        if (a == ACT_READ) begin
          if (cmd_nxt == OP_RECV) begin
            if (sda_in) shift_nxt[~grp_nxt] = 1'b1;
          end else begin
            ackl_nxt = sda_in;
          end
        end
        tc_nxt = 16'd0;
        if ((6'(idx_nxt) + 6'd1) >= 6'(step_total(cmd_nxt))) begin
          run_nxt = 1'b0;
          done    = 1'b1;
          if (cmd_nxt == OP_RECV)      rxb_nxt = shift_nxt;
          else if (cmd_nxt == OP_RACK) rxa_nxt = ackl_nxt;
        end else begin
          // receive byte: the first bit slot begins after the SDA release step
          if (!(cmd_nxt == OP_RECV && idx_nxt == 5'd0)) begin
            if (ph_nxt == 2'd2) begin
              ph_nxt  = 2'd0;
              grp_nxt = grp_nxt + 3'd1;
            end else begin
              ph_nxt = ph_nxt + 2'd1;
            end
          end
          idx_nxt = idx_nxt + 5'd1;
          a = step_action(cmd_nxt, idx_nxt, ph_nxt, grp_nxt, shift_nxt, ackl_nxt);
          apply(a, scl_nxt, sda_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r   <= TPS_RESET;
      cmd_r   <= OP_START;
      idx_r   <= 5'd0;
      ph_r    <= 2'd0;
      grp_r   <= 3'd0;
      run_r   <= 1'b0;
      tc_r    <= 16'd0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      rxb_r   <= 8'd0;
      rxa_r   <= 1'b1;
      ackl_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) tps_r <= cfg_wr_data;
      if (tick) begin
        cmd_r   <= cmd_nxt;
        idx_r   <= idx_nxt;
        ph_r    <= ph_nxt;
        grp_r   <= grp_nxt;
        run_r   <= run_nxt;
        tc_r    <= tc_nxt;
        shift_r <= shift_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        rxb_r   <= rxb_nxt;
        rxa_r   <= rxa_nxt;
        ackl_r  <= ackl_nxt;
      end
    end
  end

  always_comb begin
    res.scl     = scl_nxt;
    res.sda     = sda_nxt;
    res.busy    = run_nxt;
    res.done    = done;
    res.rx_byte = rxb_nxt;
    res.rx_ack  = rxa_nxt;
  end

endmodule
`default_nettype wire

// ----- src/i2c_master_bit_sequencer_top.sv -----
// Top level of the I2C master bit sequencer: handshakes and output register.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction is one timer tick carrying the sampled SDA level and
// an optional command (start, stop, send byte, receive byte, send ack,
// receive ack); each produces exactly one result transaction with the SCL/SDA
// drive levels, busy/done flags and the last received byte and ack. A tick is
// processed combinationally by the sequencer logic and lands in a single output
// register, so one transaction is taken per clock while out_ready is high;
// in_ready drops only while that register holds a result not yet taken.
// Every pin step lasts ticks_per_step ticks (cfg_wr_data, reset 720);
// commands offered while a sequence runs are dropped.
module i2c_master_bit_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd_valid,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_tx_byte,
  input  wire logic        in_ack_to_send,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_rx_byte,
  output logic             out_rx_ack
);
  import i2cbs_pkg::*;

  logic    tick;
  result_t res;
  result_t res_r;
  logic    ovld_r;

  assign in_ready = !ovld_r || out_ready;
  assign tick     = in_valid && in_ready;

  i2cbs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick        (tick),
    .cmd_valid   (in_cmd_valid),
    .opcode      (in_opcode),
    .tx_byte     (in_tx_byte),
    .ack_to_send (in_ack_to_send),
    .sda_in      (in_sda_in),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (in_ready) begin
      ovld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) res_r <= res;
  end

  assign out_valid    = ovld_r;
  assign out_scl_out  = res_r.scl;
  assign out_sda_out  = res_r.sda;
  assign out_busy_res = res_r.busy;
  assign out_done_res = res_r.done;
  assign out_rx_byte  = res_r.rx_byte;
  assign out_rx_ack   = res_r.rx_ack;

endmodule
`default_nettype wire
